// ===== rtl/core/fixed_weight_word_unrank_macros.svh =====
// Assertion macros for the checker file of the fixed-weight unranker.
// No dependencies; include by bare file name.
`ifndef FIXED_WEIGHT_WORD_UNRANK_MACROS_SVH
`define FIXED_WEIGHT_WORD_UNRANK_MACROS_SVH

// same-cycle implication
`define FWWU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FWWU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fwwu_pkg.sv =====
// Shared constants and types for the fixed-weight word unranker.
// No dependencies.
package fwwu_pkg;

  localparam int RANK_W      = 57;
  localparam int WORD_W      = 60;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_ZSCAN,
    ST_BITS,
    ST_RESULT
  } state_t;

endpackage

// ===== rtl/core/fwwu_ram.sv =====
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
module fwwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/fwwu_fill.sv =====
// Post-reset sweep that builds the Pascal triangle in the coefficient RAM,
// row by row: C(i,j) = C(i-1,j) + C(i-1,j-1). Uses one RAM read port.
module fwwu_fill #(
  parameter int MAX_BITS = 60,
  localparam int DEPTH  = MAX_BITS * MAX_BITS,
  localparam int AW     = $clog2(DEPTH),
  localparam int COEF_W = MAX_BITS - 1
) (
  input  logic              clk,
  input  logic              rst,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output logic [COEF_W-1:0] wdata,
  output logic [AW-1:0]     raddr,
  input  logic [COEF_W-1:0] rdata,
  output logic              done
);

  localparam int JW = $clog2(MAX_BITS);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROW_LEN = AW'(MAX_BITS);
  localparam logic [JW-1:0] COL_MAX = JW'(MAX_BITS - 1);

  // issue stage
  logic [AW-1:0] fa;
  logic [JW-1:0] fj;
  logic          frow0;
  logic          busy;
  // write stage
  logic              wv;
  logic [AW-1:0]     wa;
  logic              wj0;
  logic              wrow0;
  logic [COEF_W-1:0] prev;

  assign raddr = fa - ROW_LEN;

  always_ff @(posedge clk) begin
    if (rst) begin
      fa    <= '0;
      fj    <= '0;
      frow0 <= 1'b1;
      busy  <= 1'b1;
      wv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      wv <= busy;
      if (busy) begin
        if (fa == LAST) begin
          busy <= 1'b0;
        end else begin
          fa <= fa + AW'(1);
          if (fj == COL_MAX) begin
            fj    <= '0;
            frow0 <= 1'b0;
          end else begin
            fj <= fj + JW'(1);
          end
        end
      end
      if (wv && (wa == LAST)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa    <= fa;
    wj0   <= (fj == '0);
    wrow0 <= frow0;
    if (wv) begin
      prev <= rdata;
    end
  end

  always_comb begin
    we    = wv;
    waddr = wa;
    if (wrow0) begin
      wdata = wj0 ? COEF_W'(1) : '0;
    end else if (wj0) begin
      wdata = rdata;
    end else begin
      wdata = rdata + prev;
    end
  end

endmodule

// ===== rtl/core/fixed_weight_word_unrank.sv =====
// Top level of the fixed-weight word unranker: stream ports, decode sequencer.
// Depends on fwwu_pkg, fwwu_ram, fwwu_fill.
//
// Usage:
//   Input beat on s_axis: a 1-based rank (rank 0 acts as rank 1). Output beat
//   on m_axis: the rank-th smallest integer with exactly ONES set bits, or a
//   zero word with tuser[0] set when the rank is past C(MAX_BITS, ONES).
//   One output beat per input beat, in order.
// Reset: rst clears control and starts a sweep that writes the binomial
//   table into the RAM; s_axis_tready stays low until it is done.
// Timing: one item at a time. From accept, z+1 zero-count probes, z+ONES-1
//   bit steps after the leading one and a load of the output register; the
//   sequencer returns to idle before the next accept. The decode loop is
//   single-step: both candidate next coefficients are read on the two RAM
//   read ports so a step completes every cycle.
// Stall: the result waits in the output register while m_axis_tready is low;
//   the next rank may already be accepted and decoded, and it then waits
//   until the register is free.
module fixed_weight_word_unrank #(
  parameter int ONES     = 30,
  parameter int MAX_BITS = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [56:0] rank, [63:57] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [59:0] word, [63:60] zero
  output logic [0:0]  m_axis_tuser    // [0] out_of_range
);

  localparam int RANK_W  = fwwu_pkg::RANK_W;
  localparam int WORD_W  = fwwu_pkg::WORD_W;
  localparam int OTD_W   = fwwu_pkg::OUT_TDATA_W;
  localparam int DEPTH   = MAX_BITS * MAX_BITS;
  localparam int AW      = $clog2(DEPTH);
  localparam int COEF_W  = MAX_BITS - 1;
  localparam int CNT_W   = $clog2(MAX_BITS + 1);
  localparam int CMP_W   = (COEF_W > RANK_W) ? COEF_W : RANK_W;
  localparam bit NO_WORDS = (ONES > MAX_BITS);
  localparam int MAX_Z   = NO_WORDS ? 0 : (MAX_BITS - ONES);
  localparam int Z0_I    = NO_WORDS ? 0 : ((ONES - 1) * MAX_BITS);

  localparam logic [AW-1:0]    Z0_ADDR   = AW'(Z0_I);
  localparam logic [AW-1:0]    STEP_ONE  = AW'(MAX_BITS);
  localparam logic [AW-1:0]    STEP_ZERO = AW'(MAX_BITS + 1);
  localparam logic [CNT_W-1:0] MAX_Z_C   = CNT_W'(MAX_Z);
  localparam logic [CNT_W-1:0] ONES_M1   = CNT_W'(ONES - 1);

  fwwu_pkg::state_t state, state_next;

  logic [RANK_W-1:0]   left, left_next;
  logic [CNT_W-1:0]    zc, zc_next;          // zero-count probe, then zeros left
  logic [CNT_W-1:0]    ones_left, ones_left_next;
  logic [MAX_BITS-1:0] word, word_next;
  logic                oor, oor_next;
  logic [AW-1:0]       addr, addr_next;      // coefficient address of this step
  logic                sel_one, sel_one_next; // step's coefficient sits on port A
  logic                res_load;

  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic              out_oor;

  // RAM and fill
  logic              fill_we, fill_done;
  logic [AW-1:0]     fill_waddr, fill_raddr;
  logic [COEF_W-1:0] fill_wdata;
  logic [AW-1:0]     rd_a, rd_b, walk_rd_a;
  logic [COEF_W-1:0] rdata_a, rdata_b;

  // decode datapath
  logic [RANK_W-1:0] rank_in;
  logic [COEF_W-1:0] coef;
  logic              coef_ge_left;
  logic              bit_one;
  logic [CNT_W-1:0]  zc_dec, ones_dec;

  fwwu_fill #(.MAX_BITS(MAX_BITS)) u_fill (
    .clk   (clk),
    .rst   (rst),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (rdata_a),
    .done  (fill_done)
  );

  fwwu_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (fill_we),
    .waddr   (fill_waddr),
    .wdata   (fill_wdata),
    .raddr_a (rd_a),
    .rdata_a (rdata_a),
    .raddr_b (rd_b),
    .rdata_b (rdata_b)
  );

  assign rd_a = (state == fwwu_pkg::ST_FILL) ? fill_raddr : walk_rd_a;

  assign rank_in      = s_axis_tdata[RANK_W-1:0];
  assign coef         = (state == fwwu_pkg::ST_BITS && !sel_one) ? rdata_b : rdata_a;
  assign coef_ge_left = (CMP_W'(coef) >= CMP_W'(left));
  assign zc_dec       = zc - CNT_W'(1);
  assign ones_dec     = ones_left - CNT_W'(1);

  always_comb begin
    if (zc == '0) begin
      bit_one = 1'b1;
    end else if (ones_left == '0) begin
      bit_one = 1'b0;
    end else begin
      bit_one = !coef_ge_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fwwu_pkg::ST_FILL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    left      <= left_next;
    zc        <= zc_next;
    ones_left <= ones_left_next;
    word      <= word_next;
    oor       <= oor_next;
    addr      <= addr_next;
    sel_one   <= sel_one_next;
    if (res_load) begin
      out_word <= WORD_W'(word);
      out_oor  <= oor;
    end
  end

  always_comb begin
    state_next     = state;
    left_next      = left;
    zc_next        = zc;
    ones_left_next = ones_left;
    word_next      = word;
    oor_next       = oor;
    addr_next      = addr;
    sel_one_next   = sel_one;
    res_load       = 1'b0;
    s_axis_tready  = 1'b0;
    walk_rd_a      = addr + STEP_ZERO;
    rd_b           = addr - STEP_ZERO;

    unique case (state)
      fwwu_pkg::ST_FILL: begin
        if (fill_done) begin
          state_next = fwwu_pkg::ST_IDLE;
        end
      end
      fwwu_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        walk_rd_a     = Z0_ADDR;
        if (s_axis_tvalid) begin
          left_next = (rank_in == '0) ? RANK_W'(1) : rank_in;
          zc_next   = '0;
          addr_next = Z0_ADDR;
          oor_next  = NO_WORDS;
          word_next = '0;
          state_next = NO_WORDS ? fwwu_pkg::ST_RESULT : fwwu_pkg::ST_ZSCAN;
        end
      end
      fwwu_pkg::ST_ZSCAN: begin
        // coef = C(ONES-1+z, z): words of this length with the leading one
        if (coef_ge_left) begin
          ones_left_next = ONES_M1;
          word_next      = MAX_BITS'(1);
          addr_next      = addr - STEP_ZERO;
          sel_one_next   = 1'b0;
          state_next     = ((zc == '0) && (ONES == 1)) ? fwwu_pkg::ST_RESULT
                                                        : fwwu_pkg::ST_BITS;
        end else begin
          left_next = RANK_W'(CMP_W'(left) - CMP_W'(coef));
          if (zc == MAX_Z_C) begin
            oor_next   = 1'b1;
            word_next  = '0;
            state_next = fwwu_pkg::ST_RESULT;
          end else begin
            zc_next   = zc + CNT_W'(1);
            addr_next = addr + STEP_ZERO;
          end
        end
      end
      fwwu_pkg::ST_BITS: begin
        // prefetch both possible next coefficients
        walk_rd_a = addr - STEP_ONE;
        word_next = {word[MAX_BITS-2:0], bit_one};
        if (bit_one) begin
          if ((zc != '0) && (ones_left != '0)) begin
            left_next = RANK_W'(CMP_W'(left) - CMP_W'(coef));
          end
          ones_left_next = ones_dec;
          addr_next      = addr - STEP_ONE;
          sel_one_next   = 1'b1;
          if ((zc == '0) && (ones_dec == '0)) begin
            state_next = fwwu_pkg::ST_RESULT;
          end
        end else begin
          zc_next      = zc_dec;
          addr_next    = addr - STEP_ZERO;
          sel_one_next = 1'b0;
          if ((zc_dec == '0) && (ones_left == '0)) begin
            state_next = fwwu_pkg::ST_RESULT;
          end
        end
      end
      fwwu_pkg::ST_RESULT: begin
        if (!out_valid || m_axis_tready) begin
          res_load   = 1'b1;
          state_next = fwwu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fwwu_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {{(OTD_W - WORD_W){1'b0}}, out_word};
  assign m_axis_tuser[0] = out_oor;

endmodule

// ===== rtl/core/fwwu_checker.sv =====
// Port-level checker for the fixed-weight word unranker, bound to the top.
// Depends on fwwu_pkg and fixed_weight_word_unrank_macros.svh.
`include "fixed_weight_word_unrank_macros.svh"

module fwwu_checker #(
  parameter int ONES = 30
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,   // [59:0] word
  input logic [0:0]  m_axis_tuser    // [0] out_of_range
);

  localparam int WORD_W = fwwu_pkg::WORD_W;

  logic [WORD_W-1:0] word;
  logic [64:0]       out_bus;
  logic              s_beat;
  logic              oor_beat;
  logic              word_beat;
  logic              stalled;

  assign word      = m_axis_tdata[WORD_W-1:0];
  assign out_bus   = {m_axis_tuser, m_axis_tdata};
  assign s_beat    = s_axis_tvalid && s_axis_tready;
  assign oor_beat  = m_axis_tvalid && m_axis_tuser[0];
  assign word_beat = m_axis_tvalid && !m_axis_tuser[0];
  assign stalled   = m_axis_tvalid && !m_axis_tready;

  `FWWU_ASSERT_NOW(a_oor_zero, clk, rst, oor_beat, m_axis_tdata == '0, "nonzero word on range flag")
  `FWWU_ASSERT_NOW(a_weight, clk, rst, word_beat, $countones(word) == ONES, "wrong set-bit count")
  `FWWU_ASSERT_NXT(a_one_at_a_time, clk, rst, s_beat, !s_axis_tready, "rank taken mid-decode")
  `FWWU_ASSERT_NXT(a_hold, clk, rst, stalled, m_axis_tvalid && $stable(out_bus), "held beat changed")

endmodule

bind fixed_weight_word_unrank fwwu_checker #(.ONES(ONES)) u_fwwu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
